// ----- rtl/core/tilt_and_wheel_speed_estimator_defines.svh -----
// assertion macros shared by the estimator rtl
`ifndef TILT_AND_WHEEL_SPEED_ESTIMATOR_DEFINES_SVH
`define TILT_AND_WHEEL_SPEED_ESTIMATOR_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define TWSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("estimator check failed: same-cycle implication");

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define TWSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("estimator check failed: next-cycle implication");

`endif

// ----- rtl/core/twse_pkg.sv -----
// shared constants and types of the tilt and wheel speed estimator
package twse_pkg;

    localparam int DATA_W     = 32;
    localparam int BLEND_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int WINDOW_DEF = 100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_A      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_B      = 3'd4;

    // register reset values
    localparam logic [BLEND_W-1:0] RST_BLEND_WEIGHT  = 16'd65143;
    localparam logic [DATA_W-1:0]  RST_SAMPLE_PERIOD = 32'd4294967;
    localparam logic [DATA_W-1:0]  RST_SPEED_SCALE   = 32'd65536;

    // unity in q1.16, one bit wider than the blend weight
    localparam logic [BLEND_W:0] ONE_Q16 = 17'h10000;

    // int32 bounds
    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    // control of one serial multiplier
    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctrl;

endpackage

// ----- rtl/core/twse_ram.sv -----
// generic single write port ram with registered read
module twse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/twse_smul.sv -----
// bit-serial signed by unsigned multiplier, one multiplier bit per cycle while step is set
module twse_smul (
    input  logic                          i_clk,
    input  twse_pkg::t_mul_ctrl           i_ctrl,
    input  logic [twse_pkg::DATA_W-1:0]   i_mcand,
    input  logic [twse_pkg::DATA_W-1:0]   i_mplier,
    output logic [2*twse_pkg::DATA_W-1:0] o_prod
);
    import twse_pkg::*;

    logic [DATA_W-1:0] r_m;
    logic [DATA_W:0]   r_hi;
    logic [DATA_W-1:0] r_lo;
    logic [DATA_W+1:0] w_sum;
    logic [DATA_W+1:0] w_add;

    // partial product of the current multiplier bit
    assign w_add = r_lo[0] ? {{2{r_m[DATA_W-1]}}, r_m} : '0;
    assign w_sum = {r_hi[DATA_W], r_hi} + w_add;

    // shift-add accumulator, multiplier bits shift out of the low half
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_m  <= i_mcand;
            r_hi <= '0;
            r_lo <= i_mplier;
        end else if (i_ctrl.step) begin
            r_hi <= w_sum[DATA_W+1:1];
            r_lo <= {w_sum[0], r_lo[DATA_W-1:1]};
        end
    end

    assign o_prod = {r_hi[DATA_W-1:0], r_lo};

endmodule

// ----- rtl/core/tilt_and_wheel_speed_estimator.sv -----
// Tilt and wheel speed estimator, top level.
// Input channel (i_valid / o_ready) takes one beat per sample tick: two raw
// encoder counts, a gyro rate and an accelerometer angle. Output channel
// (o_valid / i_ready) gives one beat per input beat: both wheel speeds, the
// fused tilt, the robot speed and its moving mean over WINDOW samples.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data).
// It is to be written by the user only while the block is idle; the block
// itself does not enforce this.
// The bit-serial multipliers form the wheel and gyro products, then the
// blend products, and the restoring divider forms the moving mean.
// A new beat is taken once the previous one has left the datapath, so one
// item is in flight at a time.
// Reset (synchronous, active low) restores the register defaults and clears
// the filter state, then runs a clearing pass over the speed history ram,
// during which o_ready stays low.
// A finished result sits in the output register while the receiver stalls;
// the next input beat is still accepted, and the block waits for the output
// register only before handing over the following result.
`include "tilt_and_wheel_speed_estimator_defines.svh"
module tilt_and_wheel_speed_estimator #(
    parameter int WINDOW = twse_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [twse_pkg::DATA_W-1:0]  i_encoder_count_a,
    input  logic signed [twse_pkg::DATA_W-1:0]  i_encoder_count_b,
    input  logic signed [twse_pkg::DATA_W-1:0]  i_gyro_rate,
    input  logic signed [twse_pkg::DATA_W-1:0]  i_accel_angle,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [twse_pkg::DATA_W-1:0]  o_wheel_speed_a,
    output logic signed [twse_pkg::DATA_W-1:0]  o_wheel_speed_b,
    output logic signed [twse_pkg::DATA_W-1:0]  o_tilt_estimate,
    output logic signed [twse_pkg::DATA_W-1:0]  o_robot_speed,
    output logic signed [twse_pkg::DATA_W-1:0]  o_average_speed,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [twse_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [twse_pkg::DATA_W-1:0]         i_cfg_data
);
    import twse_pkg::*;

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int SUM_W   = DATA_W + 1 + SLOT_W;
    localparam int MCNT_W  = $clog2(DATA_W);
    localparam int DCNT_W  = $clog2(SUM_W);
    localparam int PROD_W  = 2 * DATA_W;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [SLOT_W:0]   WIN_C     = (SLOT_W + 1)'(WINDOW);
    localparam logic [SUM_W-1:0]  WIN_M1    = SUM_W'(WINDOW - 1);
    localparam logic [MCNT_W-1:0] MCNT_LAST = MCNT_W'(DATA_W - 1);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(SUM_W - 1);
    localparam logic [PROD_W-1:0] RND_STEP  = PROD_W'(1) << (DATA_W - 1);
    localparam logic [PROD_W-1:0] RND_MIX   = PROD_W'(1) << (BLEND_W - 1);

    // state codes
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_POST1 = 4'd3;
    localparam logic [3:0] S_POST2 = 4'd4;
    localparam logic [3:0] S_POST3 = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_BLEND = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // saturate a 64-bit two's complement value to int32
    function automatic logic [DATA_W-1:0] sat64(input logic [PROD_W-1:0] v);
        logic ovf;
        ovf = (v[PROD_W-1:DATA_W-1] != {(DATA_W + 1){v[PROD_W-1]}});
        if (ovf) begin
            return v[PROD_W-1] ? S32_MIN : S32_MAX;
        end
        return v[DATA_W-1:0];
    endfunction

    // configuration registers
    logic [BLEND_W-1:0] r_blend;
    logic [DATA_W-1:0]  r_period;
    logic [DATA_W-1:0]  r_scale;
    logic               r_inv_a;
    logic               r_inv_b;

    // filter state
    logic [DATA_W-1:0]  r_prev_a;
    logic [DATA_W-1:0]  r_prev_b;
    logic [DATA_W-1:0]  r_fused;
    logic [SUM_W-1:0]   r_sum;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_clr;

    // sequencer
    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic [MCNT_W-1:0]  r_cnt;

    // intermediate results
    logic [DATA_W-1:0]  r_accel;
    logic [DATA_W-1:0]  r_spd_a;
    logic [DATA_W-1:0]  r_spd_b;
    logic [DATA_W-1:0]  r_step;
    logic [DATA_W-1:0]  r_pred;
    logic [DATA_W-1:0]  r_robot;

    // output register
    logic               r_o_valid;
    logic [DATA_W-1:0]  r_o_spd_a;
    logic [DATA_W-1:0]  r_o_spd_b;
    logic [DATA_W-1:0]  r_o_tilt;
    logic [DATA_W-1:0]  r_o_robot;
    logic [DATA_W-1:0]  r_o_mean;

    // moving mean divider
    logic               r_div_start;
    logic               r_div_busy;
    logic               r_div_neg;
    logic [SUM_W-1:0]   r_div_n;
    logic [SLOT_W-1:0]  r_div_r;
    logic [DCNT_W-1:0]  r_div_cnt;

    logic               w_accept;
    logic               w_out_load;
    logic               w_ram_we;
    logic [SLOT_W-1:0]  w_ram_waddr;
    logic [DATA_W-1:0]  w_ram_wdata;
    logic [DATA_W-1:0]  w_ram_rdata;

    t_mul_ctrl          w_ctrl_ab;
    t_mul_ctrl          w_ctrl_c;
    logic [DATA_W-1:0]  w_mcand_a;
    logic [DATA_W-1:0]  w_mcand_b;
    logic [DATA_W-1:0]  w_mplier_a;
    logic [DATA_W-1:0]  w_mplier_b;
    logic [PROD_W-1:0]  w_prod_a;
    logic [PROD_W-1:0]  w_prod_b;
    logic [PROD_W-1:0]  w_prod_c;

    logic [PROD_W-1:0]  w_sgn_a;
    logic [PROD_W-1:0]  w_sgn_b;
    logic [PROD_W-1:0]  w_step_sum;
    logic [DATA_W:0]    w_pred_sum;
    logic [DATA_W:0]    w_rob_sum;
    logic [PROD_W-1:0]  w_mix;
    logic [SUM_W-1:0]   w_div_load;
    logic [SLOT_W:0]    w_div_t;
    logic               w_div_ge;
    logic [SLOT_W:0]    w_div_rem;
    logic [DATA_W-1:0]  w_mean;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid & o_ready;
    assign w_out_load = (r_state == S_OUT) && !r_div_busy && !r_div_start
                        && (!r_o_valid || i_ready);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend  <= RST_BLEND_WEIGHT;
            r_period <= RST_SAMPLE_PERIOD;
            r_scale  <= RST_SPEED_SCALE;
            r_inv_a  <= 1'b0;
            r_inv_b  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLEND_WEIGHT:  r_blend  <= i_cfg_data[BLEND_W-1:0];
                CFG_SAMPLE_PERIOD: r_period <= i_cfg_data;
                CFG_SPEED_SCALE:   r_scale  <= i_cfg_data;
                CFG_INVERT_A:      r_inv_a  <= i_cfg_data[0];
                CFG_INVERT_B:      r_inv_b  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // serial multiplier operands: wheel products first, then the blend
    assign w_ctrl_ab.load = w_accept || (r_state == S_POST3);
    assign w_ctrl_ab.step = (r_state == S_MUL1) || (r_state == S_MUL2);
    assign w_ctrl_c.load  = w_accept;
    assign w_ctrl_c.step  = (r_state == S_MUL1);

    assign w_mcand_a  = (r_state == S_POST3) ? r_pred
                                             : DATA_W'(i_encoder_count_a) - r_prev_a;
    assign w_mcand_b  = (r_state == S_POST3) ? r_accel
                                             : DATA_W'(i_encoder_count_b) - r_prev_b;
    assign w_mplier_a = (r_state == S_POST3) ? DATA_W'(r_blend) : r_scale;
    assign w_mplier_b = (r_state == S_POST3) ? DATA_W'(ONE_Q16 - {1'b0, r_blend})
                                             : r_scale;

    twse_smul u_mul_a (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl_ab),
        .i_mcand  (w_mcand_a),
        .i_mplier (w_mplier_a),
        .o_prod   (w_prod_a)
    );

    twse_smul u_mul_b (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl_ab),
        .i_mcand  (w_mcand_b),
        .i_mplier (w_mplier_b),
        .o_prod   (w_prod_b)
    );

    twse_smul u_mul_c (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl_c),
        .i_mcand  (DATA_W'(i_gyro_rate)),
        .i_mplier (r_period),
        .o_prod   (w_prod_c)
    );

    // speed history ring, cleared by a sweep after reset
    assign w_ram_we    = (r_state == S_CLEAR) || (r_state == S_POST3);
    assign w_ram_waddr = (r_state == S_CLEAR) ? r_clr : r_slot;
    assign w_ram_wdata = (r_state == S_CLEAR) ? '0 : r_robot;

    twse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_slot),
        .o_rdata (w_ram_rdata)
    );

    // wheel speed sign flip, gyro step rounding
    assign w_sgn_a    = r_inv_a ? (~w_prod_a + PROD_W'(1)) : w_prod_a;
    assign w_sgn_b    = r_inv_b ? (~w_prod_b + PROD_W'(1)) : w_prod_b;
    assign w_step_sum = w_prod_c + RND_STEP;

    // predicted angle and robot speed
    assign w_pred_sum = {r_fused[DATA_W-1], r_fused} + {r_step[DATA_W-1], r_step};
    assign w_rob_sum  = {r_spd_a[DATA_W-1], r_spd_a} + {r_spd_b[DATA_W-1], r_spd_b};

    // complementary blend with rounding
    assign w_mix = w_prod_a + w_prod_b + RND_MIX;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == SLOT_LAST) n_state = S_IDLE;
            S_IDLE:  if (w_accept) n_state = S_MUL1;
            S_MUL1:  if (r_cnt == MCNT_LAST) n_state = S_POST1;
            S_POST1: n_state = S_POST2;
            S_POST2: n_state = S_POST3;
            S_POST3: n_state = S_MUL2;
            S_MUL2:  if (r_cnt == MCNT_LAST) n_state = S_BLEND;
            S_BLEND: n_state = S_OUT;
            S_OUT:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // sequencer and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_prev_a <= '0;
            r_prev_b <= '0;
            r_fused  <= '0;
            r_sum    <= '0;
            r_slot   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + SLOT_W'(1);
            end
            if ((r_state == S_MUL1) || (r_state == S_MUL2)) begin
                r_cnt <= r_cnt + MCNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (w_accept) begin
                r_prev_a <= i_encoder_count_a;
                r_prev_b <= i_encoder_count_b;
            end
            if (r_state == S_POST3) begin
                r_sum  <= r_sum
                          - {{(SUM_W - DATA_W){w_ram_rdata[DATA_W-1]}}, w_ram_rdata}
                          + {{(SUM_W - DATA_W){r_robot[DATA_W-1]}}, r_robot};
                r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);
            end
            if (r_state == S_BLEND) begin
                r_fused <= sat64({{BLEND_W{w_mix[PROD_W-1]}}, w_mix[PROD_W-1:BLEND_W]});
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_accel <= i_accel_angle;
        end
        if (r_state == S_POST1) begin
            r_spd_a <= sat64(w_sgn_a);
            r_spd_b <= sat64(w_sgn_b);
            r_step  <= w_step_sum[PROD_W-1:DATA_W];
        end
        if (r_state == S_POST2) begin
            r_pred  <= sat64({{(DATA_W - 1){w_pred_sum[DATA_W]}}, w_pred_sum});
            r_robot <= w_rob_sum[DATA_W:1];
        end
    end

    // moving mean: floor division of the running sum by the window
    assign w_div_load = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1) + WIN_M1) : r_sum;
    assign w_div_t    = {r_div_r, r_div_n[SUM_W-1]};
    assign w_div_ge   = (w_div_t >= WIN_C);
    assign w_div_rem  = w_div_ge ? (w_div_t - WIN_C) : w_div_t;
    assign w_mean     = r_div_neg ? (~r_div_n[DATA_W-1:0] + DATA_W'(1))
                                  : r_div_n[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_start <= 1'b0;
            r_div_busy  <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_POST3);
            if (r_div_start) begin
                r_div_busy <= 1'b1;
            end else if (r_div_busy && (r_div_cnt == DCNT_LAST)) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (r_div_start) begin
            r_div_n   <= w_div_load;
            r_div_r   <= '0;
            r_div_cnt <= '0;
            r_div_neg <= r_sum[SUM_W-1];
        end else if (r_div_busy) begin
            r_div_n   <= {r_div_n[SUM_W-2:0], w_div_ge};
            r_div_r   <= w_div_rem[SLOT_W-1:0];
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_spd_a <= r_spd_a;
            r_o_spd_b <= r_spd_b;
            r_o_tilt  <= r_fused;
            r_o_robot <= r_robot;
            r_o_mean  <= w_mean;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_wheel_speed_a = r_o_spd_a;
    assign o_wheel_speed_b = r_o_spd_b;
    assign o_tilt_estimate = r_o_tilt;
    assign o_robot_speed   = r_o_robot;
    assign o_average_speed = r_o_mean;

    // checks
    `TWSE_ASSERT_NXT(a_accept_starts_mul, (i_valid && o_ready), (r_state == S_MUL1))
    `TWSE_ASSERT_IMP(a_divider_free_on_accept, (i_valid && o_ready), (!r_div_busy && !r_div_start))
    `TWSE_ASSERT_IMP(a_slot_in_window, 1'b1, (r_slot <= SLOT_LAST))
    `TWSE_ASSERT_NXT(a_result_delivered, w_out_load, (o_valid && (r_state == S_IDLE)))

endmodule
